// ----- design/pkw_pkg.sv -----
// ----------------------------------------------------------------------------
// pkw_pkg: shared types and constants of the per-vertex influence keeper
// Request formats, result codes, register indexes and table geometry.
// ----------------------------------------------------------------------------
package pkw_pkg;

    // Table geometry
    localparam int VERTICES = 4096;
    localparam int SLOTS    = 8;
    localparam int ADDR_W   = 12;               // vertex index width
    localparam int SLOT_W   = 3;                // slot number width
    localparam int CNT_W    = 4;                // influence count width
    localparam int BONE_W   = 8;
    localparam int WGT_W    = 16;
    localparam int REG_W    = 13;               // configuration register width
    localparam int CIDX_W   = 2;                // configuration index width
    localparam int SUM_W    = REG_W + 1;        // base plus relative index

    // Request kinds
    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Result codes
    localparam logic [2:0] OUT_APPENDED  = 3'd0;
    localparam logic [2:0] OUT_REPLACED  = 3'd1;
    localparam logic [2:0] OUT_DISCARDED = 3'd2;
    localparam logic [2:0] OUT_RANGE     = 3'd3;
    localparam logic [2:0] OUT_READ_OK   = 3'd4;
    localparam logic [2:0] OUT_READ_NONE = 3'd5;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_BASE_VERTEX  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_VERTEX_LIMIT = 2'd1;

    localparam logic [REG_W-1:0] LIMIT_RESET = 13'd4096;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] vertex_index;
        logic [BONE_W-1:0] bone_index;
        logic [WGT_W-1:0]  weight;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [SLOT_W-1:0] slot_used;
        logic [CNT_W-1:0]  entry_total;
        logic [BONE_W-1:0] read_bone;
        logic [WGT_W-1:0]  read_weight;
    } t_out_item;

    typedef struct packed {
        logic [BONE_W-1:0] bone;
        logic [WGT_W-1:0]  weight;
    } t_slot;

    // One table row holds everything known about one vertex
    typedef struct packed {
        logic [CNT_W-1:0]      count;
        t_slot [SLOTS-1:0]     slots;
    } t_row;

endpackage

// ----- design/per_key_top8_weight_keeper_top.sv -----
// ----------------------------------------------------------------------------
// per_key_top8_weight_keeper_top: per-vertex top-eight influence table
// Keeps up to eight (bone, weight) pairs per vertex in one row-wide memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table once, one row per cycle, clearing
// every vertex count; during the sweep requests are stalled (configuration
// writes are taken as usual). After that the row of a request's vertex is read
// from the synchronous table memory when it is accepted; in the lookup state
// the row is updated, written back on an append or replace, and the result is
// loaded into the output register, waiting while that register holds a stalled
// result. A new request is taken only after the lookup state ends, so one is
// not taken before the last is through, set by the registered read of the table
// memory and its read-modify-write of a whole row. A result waiting in the
// output register does not block the next request from being accepted.
module per_key_top8_weight_keeper_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [pkw_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [pkw_pkg::REG_W-1:0]   i_cfg_data,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  pkw_pkg::t_in_item           i_in_data,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pkw_pkg::t_out_item          o_out_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state                        r_state;
    logic [pkw_pkg::ADDR_W-1:0]    r_clr_addr;
    logic [pkw_pkg::REG_W-1:0]     r_base;
    logic [pkw_pkg::REG_W-1:0]     r_limit;

    // request held while its row is looked at
    pkw_pkg::t_in_item             r_in;
    logic                          r_ok;
    logic [pkw_pkg::ADDR_W-1:0]    r_addr;

    // table memory and its registered read data
    pkw_pkg::t_row                 r_mem [pkw_pkg::VERTICES];
    pkw_pkg::t_row                 r_rd_row;

    logic                          r_out_valid;
    pkw_pkg::t_out_item            r_out;

    localparam logic [pkw_pkg::SUM_W-1:0] VERT_TOP = pkw_pkg::SUM_W'(pkw_pkg::VERTICES);
    localparam logic [pkw_pkg::ADDR_W-1:0] CLR_LAST =
        pkw_pkg::ADDR_W'(pkw_pkg::VERTICES - 1);
    localparam logic [pkw_pkg::CNT_W-1:0] CNT_FULL = pkw_pkg::CNT_W'(pkw_pkg::SLOTS);

    logic                          in_accept;
    logic                          out_free;
    logic                          load_out;
    logic [pkw_pkg::SUM_W-1:0]     abs_vertex;
    logic [pkw_pkg::SUM_W-1:0]     chk_vertex;
    logic                          n_ok;
    logic [pkw_pkg::ADDR_W-1:0]    n_addr;

    logic [pkw_pkg::CNT_W-1:0]     cnt;
    logic [pkw_pkg::SLOT_W-1:0]    min_slot;
    logic [pkw_pkg::WGT_W-1:0]     min_w;
    logic [pkw_pkg::WGT_W-1:0]     lvl_w [pkw_pkg::SLOTS];
    logic [pkw_pkg::SLOT_W-1:0]    lvl_s [pkw_pkg::SLOTS];
    pkw_pkg::t_row                 n_row;
    logic                          n_row_we;
    pkw_pkg::t_out_item            n_out;

    logic                          mem_we;
    logic [pkw_pkg::ADDR_W-1:0]    mem_waddr;
    pkw_pkg::t_row                 mem_wdata;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == ST_LOOK) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // absolute vertex (assigns only; reads use the raw index) and range check at accept
    assign abs_vertex = pkw_pkg::SUM_W'(r_base) + pkw_pkg::SUM_W'(i_in_data.vertex_index);
    assign chk_vertex = (i_in_data.func == pkw_pkg::FUNC_ASSIGN) ? abs_vertex
                        : pkw_pkg::SUM_W'(i_in_data.vertex_index);
    assign n_ok       = (chk_vertex < pkw_pkg::SUM_W'(r_limit)) && (chk_vertex < VERT_TOP);
    assign n_addr     = chk_vertex[pkw_pkg::ADDR_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= pkw_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pkw_pkg::CFG_BASE_VERTEX:  r_base  <= i_cfg_data;
                pkw_pkg::CFG_VERTEX_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // held request
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in   <= i_in_data;
            r_ok   <= n_ok;
            r_addr <= n_addr;
        end
    end

    // row update: smallest weight search, append, replace or read
    always_comb begin
        cnt = (r_rd_row.count > CNT_FULL) ? CNT_FULL : r_rd_row.count;

        // pairwise minimum tree; on a tie the lower slot wins
        for (int i = 0; i < pkw_pkg::SLOTS; i++) begin
            lvl_w[i] = r_rd_row.slots[i].weight;
            lvl_s[i] = pkw_pkg::SLOT_W'(i);
        end
        for (int span = 1; span < pkw_pkg::SLOTS; span = span * 2) begin
            for (int i = 0; i + span < pkw_pkg::SLOTS; i = i + 2 * span) begin
                if (lvl_w[i + span] < lvl_w[i]) begin
                    lvl_w[i] = lvl_w[i + span];
                    lvl_s[i] = lvl_s[i + span];
                end
            end
        end
        min_w    = lvl_w[0];
        min_slot = lvl_s[0];

        n_row    = r_rd_row;
        n_row_we = 1'b0;
        n_out    = '0;

        if (!r_ok) begin
            n_out.outcome = pkw_pkg::OUT_RANGE;
        end else if (r_in.func == pkw_pkg::FUNC_ASSIGN) begin
            if (cnt < CNT_FULL) begin
                n_row.slots[cnt[pkw_pkg::SLOT_W-1:0]].bone   = r_in.bone_index;
                n_row.slots[cnt[pkw_pkg::SLOT_W-1:0]].weight = r_in.weight;
                n_row.count       = cnt + 1'b1;
                n_row_we          = 1'b1;
                n_out.outcome     = pkw_pkg::OUT_APPENDED;
                n_out.slot_used   = cnt[pkw_pkg::SLOT_W-1:0];
                n_out.entry_total = cnt + 1'b1;
            end else if (r_in.weight > min_w) begin
                n_row.slots[min_slot].bone   = r_in.bone_index;
                n_row.slots[min_slot].weight = r_in.weight;
                n_row_we          = 1'b1;
                n_out.outcome     = pkw_pkg::OUT_REPLACED;
                n_out.slot_used   = min_slot;
                n_out.entry_total = cnt;
            end else begin
                n_out.outcome     = pkw_pkg::OUT_DISCARDED;
                n_out.entry_total = cnt;
            end
        end else begin
            n_out.slot_used   = r_in.slot;
            n_out.entry_total = cnt;
            if (pkw_pkg::CNT_W'(r_in.slot) >= cnt) begin
                n_out.outcome = pkw_pkg::OUT_READ_NONE;
            end else begin
                n_out.outcome     = pkw_pkg::OUT_READ_OK;
                n_out.read_bone   = r_rd_row.slots[r_in.slot].bone;
                n_out.read_weight = r_rd_row.slots[r_in.slot].weight;
            end
        end
    end

    // memory write port: clearing sweep or write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = n_row;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (load_out && n_row_we) begin
            mem_we = 1'b1;
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rd_row <= r_mem[n_addr];
        end
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (out_free) begin
                        r_out   <= n_out;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_accept_looks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_LOOK))
        else $error("accepted request did not move to row lookup");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |-> (r_rd_row.count <= CNT_FULL))
        else $error("stored influence count above slot count");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != ST_IDLE))
        else $error("table written while idle");

    a_result_from_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_LOOK))
        else $error("result appeared without a lookup");

    a_write_one_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_row_we && (r_in.func == pkw_pkg::FUNC_ASSIGN)
         && (n_out.outcome == pkw_pkg::OUT_REPLACED)) |-> (r_in.weight > min_w))
        else $error("replacement with a weight that is not larger");

endmodule
